[design/ppe_pkg.sv]
// Shared types and constants for the polygon plane equation block.
package ppe_pkg;

   // Fixed widths that follow from the Q8.8 vertex format.
   localparam int COORD_W     = 16;
   localparam int EDGE_PROD_W = 34;
   localparam int MAG_W       = 30;
   localparam int SQ_W        = 62;
   localparam int ROOT_W      = 63;
   localparam int LEN_W       = 31;
   localparam int NORMAL_W    = 16;
   localparam int OFFSET_W    = 24;

   localparam int NORMAL_SAT  = 32767;
   localparam int OFFSET_MAX  = 8388607;
   localparam int OFFSET_MIN_MAG = 8388608;

   // Component codes used by the sequencer.
   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_VERT,
      S_EMUL,
      S_EACC,
      S_CHECK,
      S_SHIFT,
      S_SQMUL,
      S_SQACC,
      S_SQRT_INIT,
      S_SQRT,
      S_DIVN_START,
      S_DIVN_WAIT,
      S_DMUL,
      S_DACC,
      S_DIVO_START,
      S_DIVO_WAIT,
      S_OUT
   } ppe_state_type;

   typedef struct packed {
      logic       first_store;
      logic       vert_store;
      logic       edge_mul;
      logic       edge_close;
      logic       edge_acc;
      logic [1:0] comp;
      logic       mag_load;
      logic       shift;
      logic       sq_mul;
      logic       sq_acc;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_start;
      logic       div_offset;
      logic       norm_store;
      logic       dot_mul;
      logic       dot_acc;
      logic       out_load;
   } ppe_cmd_type;

   typedef struct packed {
      logic first;
      logic full;
      logic last;
      logic degen;
      logic need_shift;
      logic sqrt_done;
      logic div_done;
      logic out_free;
   } ppe_status_type;

endpackage

[design/ppe_if.sv]
// Valid/ready channel interfaces for vertex transactions and plane transactions.
interface ppe_req_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] vert_x;
   logic signed [15:0] vert_y;
   logic signed [15:0] vert_z;
   logic        last_vertex;

   modport source (output valid, output vert_x, output vert_y, output vert_z,
                   output last_vertex, input ready);
   modport sink   (input valid, input vert_x, input vert_y, input vert_z,
                   input last_vertex, output ready);
endinterface

interface ppe_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic signed [23:0] plane_offset;
   logic        status;

   modport source (output valid, output normal_x, output normal_y, output normal_z,
                   output plane_offset, output status, input ready);
   modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                   input plane_offset, input status, output ready);
endinterface

[design/ppe_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module ppe_div import ppe_pkg::*; #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] shq_ff, shq_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   // One shift-subtract step: the numerator shifts out as quotient bits shift in.
   always_comb begin
      shq_in  = shq_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      trial   = {rem_ff, shq_ff[NUM_W-1]};
      if (start) begin
         shq_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            shq_in = {shq_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            shq_in = {shq_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shq_ff <= shq_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quo  = shq_ff;

endmodule

[design/ppe_datapath.sv]
// Datapath: vertex registers, Newell accumulators, square root, division and output register.
module ppe_datapath import ppe_pkg::*; #(
   parameter int MAX_VERTICES     = 1024,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                clock,
   input  logic                reset,
   input  ppe_cmd_type         cmd,
   output ppe_status_type      status,
   input  logic                vert_load,
   input  logic signed [15:0]  vert_x,
   input  logic signed [15:0]  vert_y,
   input  logic signed [15:0]  vert_z,
   input  logic                last_vertex,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic signed [15:0]  normal_x,
   output logic signed [15:0]  normal_y,
   output logic signed [15:0]  normal_z,
   output logic signed [23:0]  plane_offset,
   output logic                rsp_status
);

   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int NSUM_W  = EDGE_PROD_W + CNT_W + 1;
   localparam int CSUM_W  = COORD_W + CNT_W + 1;
   localparam int DPROD_W = NORMAL_W + CSUM_W;
   localparam int DOT_W   = DPROD_W + 2;
   localparam int NNUM_W  = MAG_W + 1 + NORMAL_FRAC_BITS;
   localparam int ONUM_W  = DOT_W + 1;
   localparam int DIV_NW  = (NNUM_W > ONUM_W) ? NNUM_W : ONUM_W;
   localparam int DEN_W   = CNT_W + NORMAL_FRAC_BITS;
   localparam int DIV_DW  = (DEN_W > LEN_W) ? DEN_W : LEN_W;

   logic signed [COORD_W-1:0]  vin_ff [3];
   logic signed [COORD_W-1:0]  first_ff [3];
   logic signed [COORD_W-1:0]  prev_ff [3];
   logic                       last_ff;
   logic signed [NSUM_W-1:0]   nsum_ff [3];
   logic signed [CSUM_W-1:0]   csum_ff [3];
   logic [CNT_W-1:0]           count_ff;
   logic signed [EDGE_PROD_W-1:0] eprod_ff;
   logic [NSUM_W-1:0]          mag_ff [3];
   logic [2*MAG_W-1:0]         sqprod_ff;
   logic [SQ_W-1:0]            sq_ff;
   logic [SQ_W-1:0]            rt_v_ff;
   logic [ROOT_W-1:0]          rt_res_ff;
   logic [ROOT_W-1:0]          rt_bit_ff;
   logic signed [NORMAL_W-1:0] nrm_ff [3];
   logic signed [DPROD_W-1:0]  dprod_ff;
   logic signed [DOT_W-1:0]    dot_ff;
   logic                       rsp_valid_ff;
   logic signed [NORMAL_W-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [OFFSET_W-1:0] off_ff;
   logic                       stat_ff;

   logic signed [COORD_W-1:0]  eb [3];
   logic signed [COORD_W:0]    ed [3];
   logic signed [COORD_W:0]    es [3];
   logic signed [EDGE_PROD_W-1:0] eprod;
   logic [MAG_W-1:0]           mag_sel;
   logic [ROOT_W:0]            rt_trial;
   logic [LEN_W-1:0]           len;
   logic [DOT_W-1:0]           dot_mag;
   logic [DEN_W-1:0]           den_off;
   logic [DIV_NW-1:0]          div_num;
   logic [DIV_DW-1:0]          div_den;
   logic                       div_done;
   logic [DIV_NW-1:0]          quo;
   logic [NORMAL_W-2:0]        q_sat;
   logic signed [OFFSET_W-1:0] off_val;

   // Edge terms: differences and sums of the previous vertex and the edge end.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eb[i] = cmd.edge_close ? first_ff[i] : vin_ff[i];
         ed[i] = (COORD_W+1)'(prev_ff[i]) - (COORD_W+1)'(eb[i]);
         es[i] = (COORD_W+1)'(prev_ff[i]) + (COORD_W+1)'(eb[i]);
      end
      case (cmd.comp)
         COMP_X:  eprod = ed[1] * es[2];
         COMP_Y:  eprod = ed[2] * es[0];
         COMP_Z:  eprod = ed[0] * es[1];
         default: eprod = '0;
      endcase
   end

   assign mag_sel  = mag_ff[cmd.comp][MAG_W-1:0];
   assign rt_trial = {1'b0, rt_res_ff} + {1'b0, rt_bit_ff};
   assign len      = rt_res_ff[LEN_W-1:0];
   assign dot_mag  = dot_ff[DOT_W-1] ? DOT_W'(-dot_ff) : DOT_W'(dot_ff);
   assign den_off  = DEN_W'(count_ff) << NORMAL_FRAC_BITS;

   // Divider operands: normal component over length, or dot over scaled count.
   always_comb begin
      if (cmd.div_offset) begin
         div_num = DIV_NW'(dot_mag) + DIV_NW'(den_off >> 1);
         div_den = DIV_DW'(den_off);
      end else begin
         div_num = (DIV_NW'(mag_sel) << NORMAL_FRAC_BITS) + DIV_NW'(len[LEN_W-1:1]);
         div_den = DIV_DW'(len);
      end
   end

   ppe_div #(.NUM_W(DIV_NW), .DEN_W(DIV_DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   // Quotient saturation for the normal and the signed, clamped offset.
   always_comb begin
      q_sat = (|quo[DIV_NW-1:NORMAL_W-1]) ? (NORMAL_W-1)'(NORMAL_SAT)
                                          : quo[NORMAL_W-2:0];
      if (dot_ff[DOT_W-1]) begin
         off_val = (quo > DIV_NW'(OFFSET_MAX)) ? OFFSET_W'(OFFSET_MAX)
                                               : quo[OFFSET_W-1:0];
      end else begin
         off_val = (quo > DIV_NW'(OFFSET_MIN_MAG)) ? OFFSET_W'(OFFSET_MIN_MAG)
                                                   : OFFSET_W'(-quo[OFFSET_W-1:0]);
      end
   end

   // Loop accumulators and count, cleared when the result is loaded.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            nsum_ff[i] <= '0;
            csum_ff[i] <= '0;
         end
      end else if (cmd.out_load) begin
         count_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            nsum_ff[i] <= '0;
            csum_ff[i] <= '0;
         end
      end else begin
         if (cmd.first_store) begin
            count_ff <= CNT_W'(1);
         end else if (cmd.vert_store) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.first_store || cmd.vert_store) begin
            for (int i = 0; i < 3; i++) begin
               csum_ff[i] <= csum_ff[i] + CSUM_W'(vin_ff[i]);
            end
         end
         if (cmd.edge_acc) begin
            nsum_ff[cmd.comp] <= nsum_ff[cmd.comp] + NSUM_W'(eprod_ff);
         end
      end
   end

   // Vertex registers and the normalization datapath.
   always_ff @(posedge clock) begin
      if (vert_load) begin
         vin_ff[0] <= vert_x;
         vin_ff[1] <= vert_y;
         vin_ff[2] <= vert_z;
         last_ff   <= last_vertex;
      end
      if (cmd.first_store) begin
         first_ff <= vin_ff;
      end
      if (cmd.first_store || cmd.vert_store) begin
         prev_ff <= vin_ff;
      end
      if (cmd.edge_mul) begin
         eprod_ff <= eprod;
      end
      if (cmd.mag_load) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= nsum_ff[i][NSUM_W-1] ? NSUM_W'(-nsum_ff[i]) : NSUM_W'(nsum_ff[i]);
         end
         sq_ff  <= '0;
         dot_ff <= '0;
      end else begin
         if (cmd.shift) begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= mag_ff[i] >> 1;
            end
         end
         if (cmd.sq_acc) begin
            sq_ff <= sq_ff + SQ_W'(sqprod_ff);
         end
         if (cmd.dot_acc) begin
            dot_ff <= dot_ff + DOT_W'(dprod_ff);
         end
      end
      if (cmd.sq_mul) begin
         sqprod_ff <= mag_sel * mag_sel;
      end
      if (cmd.sqrt_init) begin
         rt_v_ff   <= sq_ff;
         rt_res_ff <= '0;
         rt_bit_ff <= ROOT_W'(1) << (ROOT_W - 1);
      end else if (cmd.sqrt_step) begin
         if ({2'b00, rt_v_ff} >= rt_trial) begin
            rt_v_ff   <= SQ_W'({2'b00, rt_v_ff} - rt_trial);
            rt_res_ff <= (rt_res_ff >> 1) + rt_bit_ff;
         end else begin
            rt_res_ff <= rt_res_ff >> 1;
         end
         rt_bit_ff <= rt_bit_ff >> 2;
      end
      if (cmd.norm_store) begin
         nrm_ff[cmd.comp] <= nsum_ff[cmd.comp][NSUM_W-1] ? NORMAL_W'({1'b0, q_sat})
                                                         : NORMAL_W'(-{1'b0, q_sat});
      end
      if (cmd.dot_mul) begin
         dprod_ff <= nrm_ff[cmd.comp] * csum_ff[cmd.comp];
      end
   end

   // Output register: one plane transaction held until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         if (status.degen) begin
            nx_ff   <= '0;
            ny_ff   <= '0;
            nz_ff   <= '0;
            off_ff  <= '0;
            stat_ff <= 1'b1;
         end else begin
            nx_ff   <= nrm_ff[0];
            ny_ff   <= nrm_ff[1];
            nz_ff   <= nrm_ff[2];
            off_ff  <= off_val;
            stat_ff <= 1'b0;
         end
      end
   end

   // Status toward the sequencer.
   always_comb begin
      status.first      = (count_ff == '0);
      status.full       = (count_ff == CNT_W'(MAX_VERTICES));
      status.last       = last_ff;
      status.degen      = (nsum_ff[0] == '0) && (nsum_ff[1] == '0) && (nsum_ff[2] == '0);
      status.need_shift = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (|mag_ff[i][NSUM_W-1:MAG_W]) begin
            status.need_shift = 1'b1;
         end
      end
      status.sqrt_done  = (rt_bit_ff == '0);
      status.div_done   = div_done;
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign normal_x     = nx_ff;
   assign normal_y     = ny_ff;
   assign normal_z     = nz_ff;
   assign plane_offset = off_ff;
   assign rsp_status   = stat_ff;

endmodule

[design/ppe_ctrl.sv]
// Sequencer that steps the datapath through edge sums and the final normalization.
module ppe_ctrl import ppe_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  ppe_status_type status,
   output ppe_cmd_type    cmd
);

   ppe_state_type state_ff, state_in;
   logic [1:0]    comp_ff, comp_in;
   logic          close_ff, close_in;

   // Next state, component index and closing-edge flag.
   always_comb begin
      state_in = state_ff;
      comp_in  = comp_ff;
      close_in = close_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_VERT;
         end
         S_VERT: begin
            comp_in = COMP_X;
            if (!status.first && !status.full) begin
               close_in = 1'b0;
               state_in = S_EMUL;
            end else if (status.last) begin
               close_in = 1'b1;
               state_in = S_EMUL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMUL: state_in = S_EACC;
         S_EACC: begin
            if (comp_ff != COMP_Z) begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_EMUL;
            end else if (close_ff) begin
               state_in = S_CHECK;
            end else if (status.last) begin
               comp_in  = COMP_X;
               close_in = 1'b1;
               state_in = S_EMUL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CHECK: state_in = status.degen ? S_OUT : S_SHIFT;
         S_SHIFT: begin
            if (!status.need_shift) begin
               comp_in  = COMP_X;
               state_in = S_SQMUL;
            end
         end
         S_SQMUL: state_in = S_SQACC;
         S_SQACC: begin
            if (comp_ff != COMP_Z) begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_SQMUL;
            end else begin
               state_in = S_SQRT_INIT;
            end
         end
         S_SQRT_INIT: state_in = S_SQRT;
         S_SQRT: begin
            if (status.sqrt_done) begin
               comp_in  = COMP_X;
               state_in = S_DIVN_START;
            end
         end
         S_DIVN_START: state_in = S_DIVN_WAIT;
         S_DIVN_WAIT: begin
            if (status.div_done) begin
               if (comp_ff != COMP_Z) begin
                  comp_in  = comp_ff + 1'b1;
                  state_in = S_DIVN_START;
               end else begin
                  comp_in  = COMP_X;
                  state_in = S_DMUL;
               end
            end
         end
         S_DMUL: state_in = S_DACC;
         S_DACC: begin
            if (comp_ff != COMP_Z) begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_DMUL;
            end else begin
               state_in = S_DIVO_START;
            end
         end
         S_DIVO_START: state_in = S_DIVO_WAIT;
         S_DIVO_WAIT: begin
            if (status.div_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd            = '0;
      cmd.comp       = comp_ff;
      cmd.edge_close = close_ff;
      req_ready      = 1'b0;
      unique case (state_ff)
         S_IDLE:       req_ready = 1'b1;
         S_VERT:       cmd.first_store = status.first;
         S_EMUL:       cmd.edge_mul = 1'b1;
         S_EACC: begin
            cmd.edge_acc   = 1'b1;
            cmd.vert_store = (comp_ff == COMP_Z) && !close_ff;
         end
         S_CHECK:      cmd.mag_load = 1'b1;
         S_SHIFT:      cmd.shift = status.need_shift;
         S_SQMUL:      cmd.sq_mul = 1'b1;
         S_SQACC:      cmd.sq_acc = 1'b1;
         S_SQRT_INIT:  cmd.sqrt_init = 1'b1;
         S_SQRT:       cmd.sqrt_step = !status.sqrt_done;
         S_DIVN_START: cmd.div_start = 1'b1;
         S_DIVN_WAIT:  cmd.norm_store = status.div_done;
         S_DMUL:       cmd.dot_mul = 1'b1;
         S_DACC:       cmd.dot_acc = 1'b1;
         S_DIVO_START: begin
            cmd.div_start  = 1'b1;
            cmd.div_offset = 1'b1;
         end
         S_DIVO_WAIT:  cmd.div_offset = 1'b1;
         S_OUT: begin
            cmd.div_offset = 1'b1;
            cmd.out_load   = status.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         comp_ff  <= COMP_X;
         close_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         comp_ff  <= comp_in;
         close_ff <= close_in;
      end
   end

endmodule

[design/polygon_plane_equation.sv]
// Top level of the Newell-method polygon plane equation block.
//
//   Channel | Direction | Transaction
//   req_ch  | in        | one vertex (x, y, z, last marker)
//   rsp_ch  | out       | unit normal, plane offset, degenerate status
//
// A vertex that opens a loop or is dropped past MAX_VERTICES is only stored or
// skipped; other vertices add edge terms through one shared multiplier. The last
// vertex adds the closing edge, then, unless degenerate, the shifts that bring the
// magnitudes under 30 bits, a 32-step square root and four bit-serial divisions
// before the result is loaded. Reset is synchronous and needs no clearing pass.
// A result waits in the output register; only the next loop's end waits on it.
module polygon_plane_equation import ppe_pkg::*; #(
   parameter int MAX_VERTICES     = 1024,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input logic        clock,
   input logic        reset,
   ppe_req_if.sink    req_ch,
   ppe_rsp_if.source  rsp_ch
);

   ppe_cmd_type    cmd;
   ppe_status_type status;
   logic           req_accept;

   assign req_accept = req_ch.valid && req_ch.ready;

   ppe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ppe_datapath #(
      .MAX_VERTICES     (MAX_VERTICES),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .vert_load    (req_accept),
      .vert_x       (req_ch.vert_x),
      .vert_y       (req_ch.vert_y),
      .vert_z       (req_ch.vert_z),
      .last_vertex  (req_ch.last_vertex),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .normal_x     (rsp_ch.normal_x),
      .normal_y     (rsp_ch.normal_y),
      .normal_z     (rsp_ch.normal_z),
      .plane_offset (rsp_ch.plane_offset),
      .rsp_status   (rsp_ch.status)
   );

endmodule

[design/ppe_checker.sv]
// Port-level checks on the plane equation block, bound to the top level.
module ppe_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] normal_x,
   input logic signed [15:0] normal_y,
   input logic signed [15:0] normal_z,
   input logic signed [23:0] plane_offset,
   input logic               status
);

   // A pending plane transaction stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("plane transaction withdrawn before it was taken");

   // Each vertex is worked on before the next one is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("vertex taken while the previous one is still in work");

   // A degenerate loop reports an all-zero plane.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status |->
         normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0
         && plane_offset == 24'sd0)
      else $error("degenerate status with a nonzero plane");

   // A valid plane never has a zero normal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !status |->
         normal_x != 16'sd0 || normal_y != 16'sd0 || normal_z != 16'sd0)
      else $error("valid status with a zero normal");

endmodule

bind polygon_plane_equation ppe_checker u_ppe_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .normal_x     (rsp_ch.normal_x),
   .normal_y     (rsp_ch.normal_y),
   .normal_z     (rsp_ch.normal_z),
   .plane_offset (rsp_ch.plane_offset),
   .status       (rsp_ch.status)
);

[bench/ppe_tb_if.sv]
// Channel interfaces for the testbench are those of the design; this file holds the bench clock helper.
module ppe_tb_clock_gen (output logic clock);
   timeunit 1ns;
   timeprecision 1ps;

   // Free-running bench clock with a 4 ns period.
   initial clock = 1'b0;
   always #2 clock = ~clock;
endmodule

[bench/polygon_plane_equation_tb.sv]
// Testbench for the polygon plane equation block: directed and random loops checked by a predictor.
module polygon_plane_equation_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ppe_pkg::*;

   localparam int MAX_VERTS = 1024;
   localparam int FRAC_BITS = 14;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic signed [23:0] offset;
      logic               degenerate;
   } plane_type;

   logic clock;
   logic reset;

   ppe_req_if req_ch ();
   ppe_rsp_if rsp_ch ();

   ppe_tb_clock_gen clk_gen (.clock(clock));

   polygon_plane_equation #(.MAX_VERTICES(MAX_VERTS), .NORMAL_FRAC_BITS(FRAC_BITS)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Predictor state for the loop being accumulated.
   longint first_v[3];
   longint prev_v[3];
   longint newell_sum[3];
   longint centroid_sum[3];
   int     loop_count;

   plane_type expected_planes[$];
   int     mismatch_count;
   int     idle_pct;

   // Integer square root, bit by bit.
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic void accumulate_edge(longint a[3], longint b[3]);
      newell_sum[0] += (a[1] - b[1]) * (a[2] + b[2]);
      newell_sum[1] += (a[2] - b[2]) * (a[0] + b[0]);
      newell_sum[2] += (a[0] - b[0]) * (a[1] + b[1]);
   endfunction

   function automatic void clear_plane_loop();
      for (int i = 0; i < 3; i++) begin
         newell_sum[i] = 0;
         centroid_sum[i] = 0;
      end
      loop_count = 0;
   endfunction

   // Advances the predictor by one vertex; queues a plane on the last vertex.
   function automatic void predict_plane(logic signed [15:0] x, logic signed [15:0] y,
                                         logic signed [15:0] z, logic last);
      longint          v[3];
      longint unsigned mag[3];
      longint unsigned maxm;
      longint unsigned sq;
      longint unsigned len;
      longint unsigned q;
      longint unsigned den;
      longint unsigned num;
      longint          nrm[3];
      longint          dot;
      longint          d;
      int              s;
      plane_type       p;
      v[0] = x;
      v[1] = y;
      v[2] = z;
      if (loop_count == 0) begin
         for (int i = 0; i < 3; i++) begin
            first_v[i] = v[i];
            prev_v[i] = v[i];
            centroid_sum[i] += v[i];
         end
         loop_count = 1;
      end else if (loop_count < MAX_VERTS) begin
         accumulate_edge(prev_v, v);
         for (int i = 0; i < 3; i++) begin
            prev_v[i] = v[i];
            centroid_sum[i] += v[i];
         end
         loop_count++;
      end
      if (!last) return;
      accumulate_edge(prev_v, first_v);
      p = '0;
      if (newell_sum[0] == 0 && newell_sum[1] == 0 && newell_sum[2] == 0) begin
         p.degenerate = 1'b1;
         expected_planes.push_back(p);
         clear_plane_loop();
         return;
      end
      maxm = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = newell_sum[i] < 0 ? -newell_sum[i] : newell_sum[i];
         if (mag[i] > maxm) maxm = mag[i];
      end
      s = 0;
      while ((maxm >> s) >= (64'd1 << 30)) s++;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = mag[i] >> s;
         sq += mag[i] * mag[i];
      end
      len = int_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << FRAC_BITS) + (len >> 1)) / len;
         if (q > NORMAL_SAT) q = NORMAL_SAT;
         nrm[i] = newell_sum[i] > 0 ? -longint'(q) : longint'(q);
      end
      dot = 0;
      for (int i = 0; i < 3; i++) dot += nrm[i] * centroid_sum[i];
      den = longint'(loop_count) << FRAC_BITS;
      num = dot < 0 ? -dot : dot;
      num = (num + (den >> 1)) / den;
      if (num > (64'd1 << 24)) num = 64'd1 << 24;
      d = dot < 0 ? longint'(num) : -longint'(num);
      if (d > OFFSET_MAX) d = OFFSET_MAX;
      if (d < -longint'(OFFSET_MIN_MAG)) d = -longint'(OFFSET_MIN_MAG);
      p.nx = nrm[0][15:0];
      p.ny = nrm[1][15:0];
      p.nz = nrm[2][15:0];
      p.offset = d[23:0];
      expected_planes.push_back(p);
      clear_plane_loop();
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Sends one vertex transaction and advances the predictor when it is taken.
   task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z, logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.vert_x <= x;
      req_ch.vert_y <= y;
      req_ch.vert_z <= z;
      req_ch.last_vertex <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_plane(x, y, z, last);
   endtask

   // Drops the request and waits until every predicted plane has been seen.
   task automatic wait_all_planes();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_planes.size() != 0) @(posedge clock);
   endtask

   // Checks each plane transaction against the oldest prediction.
   always @(posedge clock) begin
      plane_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_planes.size() == 0) begin
            report_mismatch("unexpected plane", 1, 0);
         end else begin
            want = expected_planes.pop_front();
            if (rsp_ch.normal_x !== want.nx) report_mismatch("normal_x", rsp_ch.normal_x, want.nx);
            if (rsp_ch.normal_y !== want.ny) report_mismatch("normal_y", rsp_ch.normal_y, want.ny);
            if (rsp_ch.normal_z !== want.nz) report_mismatch("normal_z", rsp_ch.normal_z, want.nz);
            if (rsp_ch.plane_offset !== want.offset)
               report_mismatch("plane_offset", rsp_ch.plane_offset, want.offset);
            if (rsp_ch.status !== want.degenerate)
               report_mismatch("status", rsp_ch.status, want.degenerate);
         end
      end
   end

   // Receiver stalls at the same rate as the sender idles.
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
   end

   function automatic logic signed [15:0] rand_coord(int span);
      return $signed(16'($urandom_range(2 * span))) - 16'(span);
   endfunction

   // Extremes of the coordinates and the degenerate loops.
   task automatic test_directed();
      send_vertex(16'sh7FFF, 16'sh8000, 16'sh0000, 1'b1);
      send_vertex(16'sh0100, 16'sh0200, 16'sh0300, 1'b0);
      send_vertex(16'sh0400, 16'sh0500, 16'sh0600, 1'b1);
      send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
      send_vertex(16'sh0100, 16'sh0100, 16'sh0100, 1'b0);
      send_vertex(16'sh0200, 16'sh0200, 16'sh0200, 1'b1);
      send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
      send_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0);
      send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1);
      send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
      send_vertex(16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0);
      send_vertex(16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0);
      send_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1);
      send_vertex(16'sh0000, 16'sh0000, 16'sh7FFF, 1'b0);
      send_vertex(16'sh0100, 16'sh0000, 16'sh7FFF, 1'b0);
      send_vertex(16'sh0000, 16'sh0100, 16'sh7FFF, 1'b1);
      send_vertex(16'shFFFF, 16'sh0000, 16'sh8000, 1'b0);
      send_vertex(16'sh0000, 16'shFFFF, 16'sh8000, 1'b0);
      send_vertex(16'sh0001, 16'sh0001, 16'sh8000, 1'b1);
      wait_all_planes();
   endtask

   // Overlong loop: vertices past the limit are dropped, the last still closes it.
   task automatic test_overflow_loop();
      for (int i = 0; i < MAX_VERTS + 3; i++)
         send_vertex(rand_coord(32767), rand_coord(32767), rand_coord(32767),
                     i == MAX_VERTS + 2);
   endtask

   // Random small loops, with some flat and some degenerate.
   task automatic test_random_loops(int n_loops);
      int len;
      int span;
      int kind;
      for (int k = 0; k < n_loops; k++) begin
         kind = $urandom_range(9);
         len = (kind == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
         span = ($urandom_range(1)) ? 32767 : 400;
         for (int i = 0; i < len; i++) begin
            if (kind == 1)
               send_vertex(16'(i * 64), 16'(i * 32), 16'(i * 16), i == len - 1);
            else if (kind == 2)
               send_vertex(rand_coord(span), rand_coord(span), 16'sh0123, i == len - 1);
            else
               send_vertex(rand_coord(span), rand_coord(span), rand_coord(span), i == len - 1);
         end
      end
   endtask

   // Main sequence.
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.vert_x = '0;
      req_ch.vert_y = '0;
      req_ch.vert_z = '0;
      req_ch.last_vertex = 1'b0;
      idle_pct = 37;
      mismatch_count = 0;
      clear_plane_loop();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_loops(8);
      wait_all_planes();
      idle_pct = 0;
      test_random_loops(6);
      idle_pct = 37;
      test_random_loops(8);
      test_overflow_loop();
      wait_all_planes();
      repeat (400) @(posedge clock);
      if (mismatch_count == 0 && expected_planes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #4ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
